>>> src/sabv_pkg.sv
// Shared constants, types and the arctangent table for the vector angle unit.
package sabv_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int NUM_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int SCALE_SH     = 60 - COORD_WIDTH;
   localparam int XY_W         = 63;
   localparam int Z_W          = 28;
   localparam int OUT_W        = 16;
   localparam int ROUND_SH     = 11;
   localparam int Q_W          = Z_W - ROUND_SH;
   localparam int Q_DEPTH      = 4;
   localparam int Q_PTR_W      = $clog2(Q_DEPTH);
   localparam int RSP_LATENCY  = NUM_STEPS + 7;

   localparam logic signed [Z_W-1:0] ANG_PI      = 28'sd52707179;
   localparam logic signed [Z_W-1:0] ANG_TWO_PI  = 28'sd105414357;
   localparam logic signed [Z_W-1:0] ANG_HALF_PI = 28'sd26353589;
   localparam logic signed [Z_W-1:0] ROUND_HALF  = 28'sd1024;
   localparam logic signed [Q_W-1:0] OUT_PI      = Q_W'(25736);

   localparam logic [1:0] ZC_ZERO = 2'd0;
   localparam logic [1:0] ZC_POS  = 2'd1;
   localparam logic [1:0] ZC_NEG  = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH:0] x;
      logic signed [COORD_WIDTH:0] y;
      logic [1:0]                  zc;
   } sabv_vec_type;

   typedef struct packed {
      logic         zero;
      sabv_vec_type first;
      sabv_vec_type second;
   } sabv_item_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
      unique case (idx)
         0: return 28'sd13176795;
         1: return 28'sd7778716;
         2: return 28'sd4110060;
         3: return 28'sd2086331;
         4: return 28'sd1047214;
         5: return 28'sd524117;
         6: return 28'sd262123;
         7: return 28'sd131069;
         8: return 28'sd65536;
         9: return 28'sd32768;
         10: return 28'sd16384;
         11: return 28'sd8192;
         12: return 28'sd4096;
         13: return 28'sd2048;
         14: return 28'sd1024;
         15: return 28'sd512;
         16: return 28'sd256;
         17: return 28'sd128;
         18: return 28'sd64;
         19: return 28'sd32;
         20: return 28'sd16;
         21: return 28'sd8;
         22: return 28'sd4;
         23: return 28'sd2;
         default: return '0;
      endcase
   endfunction

endpackage

>>> src/sabv_front.sv
// Front end: takes items, flags zero vectors and pre-rotates into the right half plane.
module sabv_front import sabv_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic                          queue_full,
   output logic                          push,
   output sabv_item_type                 item
);

   logic          valid_ff, valid_in;
   sabv_item_type item_ff, item_in;
   logic          take;

   function automatic sabv_vec_type pre_rotate(input logic signed [COORD_WIDTH-1:0] x,
                                               input logic signed [COORD_WIDTH-1:0] y);
      sabv_vec_type v;
      logic signed [COORD_WIDTH:0] xe;
      logic signed [COORD_WIDTH:0] ye;
      xe = {x[COORD_WIDTH-1], x};
      ye = {y[COORD_WIDTH-1], y};
      if (!xe[COORD_WIDTH]) begin
         v.x  = xe;
         v.y  = ye;
         v.zc = ZC_ZERO;
      end else if (!ye[COORD_WIDTH]) begin
         v.x  = ye;
         v.y  = -xe;
         v.zc = ZC_POS;
      end else begin
         v.x  = -ye;
         v.y  = xe;
         v.zc = ZC_NEG;
      end
      return v;
   endfunction

   assign busy = reset || (valid_ff && queue_full);
   assign take = start && !busy;
   assign push = valid_ff && !queue_full;
   assign item = item_ff;

   always_comb begin
      item_in.zero   = ((req_first_x == '0) && (req_first_y == '0)) ||
                       ((req_second_x == '0) && (req_second_y == '0));
      item_in.first  = pre_rotate(req_first_x, req_first_y);
      item_in.second = pre_rotate(req_second_x, req_second_y);
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

endmodule

>>> src/sabv_queue.sv
// Short item queue between the front end and the CORDIC back end.
module sabv_queue import sabv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sabv_item_type push_item,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output sabv_item_type head
);

   sabv_item_type        entry_ff [0:Q_DEPTH-1];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W:0]     count_ff, count_in;

   assign full      = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/sabv_lane.sv
// One pipelined CORDIC vectoring lane: one step per stage, clamped angle out.
module sabv_lane import sabv_pkg::*; (
   input  logic                  clock,
   input  sabv_vec_type          vec,
   output logic signed [Z_W-1:0] angle
);

   logic signed [XY_W-1:0] x_ff [0:NUM_STEPS];
   logic signed [XY_W-1:0] y_ff [0:NUM_STEPS];
   logic signed [Z_W-1:0]  z_ff [0:NUM_STEPS];
   logic signed [XY_W-1:0] x_in [0:NUM_STEPS];
   logic signed [XY_W-1:0] y_in [0:NUM_STEPS];
   logic signed [Z_W-1:0]  z_in [0:NUM_STEPS];
   logic signed [Z_W-1:0]  angle_ff, angle_in;

   localparam int PAD_W = XY_W - (COORD_WIDTH + 1) - SCALE_SH;

   always_comb begin
      x_in[0] = {{PAD_W{vec.x[COORD_WIDTH]}}, vec.x, {SCALE_SH{1'b0}}};
      y_in[0] = {{PAD_W{vec.y[COORD_WIDTH]}}, vec.y, {SCALE_SH{1'b0}}};
      unique case (vec.zc)
         ZC_POS:  z_in[0] = ANG_HALF_PI;
         ZC_NEG:  z_in[0] = -ANG_HALF_PI;
         default: z_in[0] = '0;
      endcase
   end

   for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
      always_comb begin
         if (y_ff[k] > 0) begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] + atan_entry(k);
         end else begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            z_in[k+1] = z_ff[k] - atan_entry(k);
         end
      end
   end

   always_comb begin
      if (z_ff[NUM_STEPS] > ANG_PI) begin
         angle_in = ANG_PI;
      end else if (z_ff[NUM_STEPS] < -ANG_PI) begin
         angle_in = -ANG_PI;
      end else begin
         angle_in = z_ff[NUM_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= NUM_STEPS; k++) begin
         x_ff[k] <= x_in[k];
         y_ff[k] <= y_in[k];
         z_ff[k] <= z_in[k];
      end
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

>>> src/sabv_back.sv
// Back end: two CORDIC lanes, angle difference, wrap, rounding and result register.
module sabv_back import sabv_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  sabv_item_type           head,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_angle
);

   localparam int TAG_LEN = NUM_STEPS + 2;

   logic                    valid_ff [0:TAG_LEN-1];
   logic                    zero_ff  [0:TAG_LEN-1];
   logic signed [Z_W-1:0]   first_angle, second_angle;

   logic                    diff_valid_ff, wrap_valid_ff, out_valid_ff;
   logic                    diff_zero_ff, wrap_zero_ff;
   logic signed [Z_W-1:0]   diff_ff, diff_in;
   logic signed [Z_W-1:0]   wrap_ff, wrap_in;
   logic signed [Q_W-1:0]   q_full;
   logic signed [OUT_W-1:0] out_ff, out_in;

   assign pop = head_valid;

   sabv_lane u_first (
      .clock (clock),
      .vec   (head.first),
      .angle (first_angle)
   );

   sabv_lane u_second (
      .clock (clock),
      .vec   (head.second),
      .angle (second_angle)
   );

   always_comb begin
      diff_in = second_angle - first_angle;
      if (diff_ff > ANG_PI) begin
         wrap_in = diff_ff - ANG_TWO_PI + ROUND_HALF;
      end else if (diff_ff < -ANG_PI) begin
         wrap_in = diff_ff + ANG_TWO_PI + ROUND_HALF;
      end else begin
         wrap_in = diff_ff + ROUND_HALF;
      end
      q_full = $signed(wrap_ff[Z_W-1:ROUND_SH]);
      if (wrap_zero_ff) begin
         out_in = '0;
      end else if (q_full > OUT_PI) begin
         out_in = OUT_PI[OUT_W-1:0];
      end else if (q_full < -OUT_PI) begin
         out_in = -OUT_PI[OUT_W-1:0];
      end else begin
         out_in = q_full[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAG_LEN; k++) begin
            valid_ff[k] <= 1'b0;
         end
         diff_valid_ff <= 1'b0;
         wrap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         valid_ff[0] <= pop;
         for (int k = 1; k < TAG_LEN; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         diff_valid_ff <= valid_ff[TAG_LEN-1];
         wrap_valid_ff <= diff_valid_ff;
         out_valid_ff  <= wrap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff[0] <= head.zero;
      for (int k = 1; k < TAG_LEN; k++) begin
         zero_ff[k] <= zero_ff[k-1];
      end
      diff_zero_ff <= zero_ff[TAG_LEN-1];
      wrap_zero_ff <= diff_zero_ff;
      diff_ff      <= diff_in;
      wrap_ff      <= wrap_in;
      out_ff       <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_angle = out_ff;

endmodule

>>> src/signed_angle_between_vectors_unit.sv
// Throughput: one item per cycle while not busy; each CORDIC step is its own pipeline stage in both lanes.
// busy is high only during reset or when the queue is full, which a non-stalling back end avoids.
// Reset: synchronous, active high; clears the front valid flag, queue pointers and valid pipeline.
// The receiver cannot stall: each result is shown for exactly one cycle.
module signed_angle_between_vectors_unit import sabv_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   output logic                          rsp_valid,
   output logic signed [OUT_W-1:0]       rsp_angle
);

   logic          queue_full;
   logic          queue_not_empty;
   logic          push;
   logic          pop;
   sabv_item_type front_item;
   sabv_item_type head_item;

   sabv_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .queue_full   (queue_full),
      .push         (push),
      .item         (front_item)
   );

   sabv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head_item)
   );

   sabv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (queue_not_empty),
      .head       (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_angle  (rsp_angle)
   );

endmodule

>>> src/sabv_checker.sv
// Port-level checks for the vector angle unit, bound to the top level.
module sabv_checker import sabv_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic signed [COORD_WIDTH-1:0] req_first_x,
   input logic signed [COORD_WIDTH-1:0] req_first_y,
   input logic signed [COORD_WIDTH-1:0] req_second_x,
   input logic signed [COORD_WIDTH-1:0] req_second_y,
   input logic                          rsp_valid,
   input logic signed [OUT_W-1:0]       rsp_angle
);

   logic accept;
   logic zero_vec;

   assign accept   = start && !busy;
   assign zero_vec = ((req_first_x == '0) && (req_first_y == '0)) ||
                     ((req_second_x == '0) && (req_second_y == '0));

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe after reset");

   a_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_angle <= 16'sd25736) && (rsp_angle >= -16'sd25736)))
      else $error("angle out of range");

   a_item_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RSP_LATENCY rsp_valid)
      else $error("accepted item gave no result");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, RSP_LATENCY))
      else $error("result without accepted item");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (accept && zero_vec) |-> ##RSP_LATENCY (rsp_valid && (rsp_angle == '0)))
      else $error("zero vector did not give zero angle");

endmodule

bind signed_angle_between_vectors_unit sabv_checker u_checker (.*);

>>> dv/sabv_angle_checker.sv
// Checker for the vector angle unit: predicts each item's angle and compares the results.
module sabv_angle_checker import sabv_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_first_x,
   input  logic signed [COORD_WIDTH-1:0] req_first_y,
   input  logic signed [COORD_WIDTH-1:0] req_second_x,
   input  logic signed [COORD_WIDTH-1:0] req_second_y,
   input  logic                          rsp_valid,
   input  logic signed [OUT_W-1:0]       rsp_angle,
   output int                            fail_count,
   output int                            pending
);
   timeunit 1ns;
   timeprecision 1ps;

   longint atan_lut [TABLE_LEN];
   logic signed [OUT_W-1:0] angle_queue [$];

   initial atan_lut = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117,
      262123, 131069, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128,
      64, 32, 16, 8, 4, 2
   };

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch: %s, got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic longint vector_heading(input logic signed [COORD_WIDTH-1:0] cx,
                                             input logic signed [COORD_WIDTH-1:0] cy);
      longint px, py, pz, shx, shy, tmp;
      px = longint'(cx) <<< SCALE_SH;
      py = longint'(cy) <<< SCALE_SH;
      pz = 0;
      if (px < 0) begin
         tmp = px;
         if (py >= 0) begin
            px = py;
            py = -tmp;
            pz = longint'(ANG_HALF_PI);
         end else begin
            px = -py;
            py = tmp;
            pz = -longint'(ANG_HALF_PI);
         end
      end
      for (int i = 0; i < NUM_STEPS; i++) begin
         shx = px >>> i;
         shy = py >>> i;
         if (py > 0) begin
            px = px + shy;
            py = py - shx;
            pz = pz + atan_lut[i];
         end else begin
            px = px - shy;
            py = py + shx;
            pz = pz - atan_lut[i];
         end
      end
      if (pz > longint'(ANG_PI)) pz = longint'(ANG_PI);
      if (pz < -longint'(ANG_PI)) pz = -longint'(ANG_PI);
      return pz;
   endfunction

   function automatic logic signed [OUT_W-1:0] predict_angle(
      input logic signed [COORD_WIDTH-1:0] fx, input logic signed [COORD_WIDTH-1:0] fy,
      input logic signed [COORD_WIDTH-1:0] sx, input logic signed [COORD_WIDTH-1:0] sy);
      longint diff, rounded;
      if ((fx == 0 && fy == 0) || (sx == 0 && sy == 0))
         return '0;
      diff = vector_heading(sx, sy) - vector_heading(fx, fy);
      if (diff > longint'(ANG_PI))
         diff = diff - longint'(ANG_TWO_PI);
      else if (diff < -longint'(ANG_PI))
         diff = diff + longint'(ANG_TWO_PI);
      rounded = (diff + longint'(ROUND_HALF)) >>> ROUND_SH;
      if (rounded > longint'(OUT_PI)) rounded = longint'(OUT_PI);
      if (rounded < -longint'(OUT_PI)) rounded = -longint'(OUT_PI);
      return OUT_W'(rounded);
   endfunction

   always @(posedge clock) begin
      logic signed [OUT_W-1:0] want;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            if (angle_queue.size() == 0) begin
               report_mismatch("result with no item outstanding", rsp_angle, 0);
            end else begin
               want = angle_queue.pop_front();
               if (rsp_angle !== want)
                  report_mismatch("angle", rsp_angle, want);
            end
         end
         if (start && !busy)
            angle_queue = {angle_queue, predict_angle(req_first_x, req_first_y,
                                                      req_second_x, req_second_y)};
         pending = angle_queue.size();
      end
   end

endmodule

>>> dv/signed_angle_between_vectors_unit_tb.sv
// Testbench top for the vector angle unit: clock, reset, stimulus, watchdog and verdict.
module signed_angle_between_vectors_unit_tb import sabv_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_COUNT   = 400;
   localparam int QUIET_TAIL   = 50;
   localparam int STALL_LIMIT  = 1000;
   localparam logic signed [COORD_WIDTH-1:0] MAX_COORD = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] MIN_COORD = ~MAX_COORD;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [COORD_WIDTH-1:0] req_first_x;
   logic signed [COORD_WIDTH-1:0] req_first_y;
   logic signed [COORD_WIDTH-1:0] req_second_x;
   logic signed [COORD_WIDTH-1:0] req_second_y;
   logic                          rsp_valid;
   logic signed [OUT_W-1:0]       rsp_angle;
   int                            fail_count;
   int                            pending;
   int                            idle_cycles;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   signed_angle_between_vectors_unit dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .rsp_valid    (rsp_valid),
      .rsp_angle    (rsp_angle)
   );

   sabv_angle_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_first_x  (req_first_x),
      .req_first_y  (req_first_y),
      .req_second_x (req_second_x),
      .req_second_y (req_second_y),
      .rsp_valid    (rsp_valid),
      .rsp_angle    (rsp_angle),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return COORD_WIDTH'(int'($urandom_range(0, 8)) - 4);
         1: begin
            case ($urandom_range(0, 5))
               0: return MIN_COORD;
               1: return COORD_WIDTH'(MIN_COORD + 1);
               2: return -1;
               3: return 0;
               4: return 1;
               default: return MAX_COORD;
            endcase
         end
         default: return COORD_WIDTH'($urandom);
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after acceptance
   task automatic send_pair(input logic signed [COORD_WIDTH-1:0] fx,
                            input logic signed [COORD_WIDTH-1:0] fy,
                            input logic signed [COORD_WIDTH-1:0] sx,
                            input logic signed [COORD_WIDTH-1:0] sy);
      start        <= 1'b1;
      req_first_x  <= fx;
      req_first_y  <= fy;
      req_second_x <= sx;
      req_second_y <= sy;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic hold_off(input int cycles);
      repeat (cycles) begin
         start        <= 1'b0;
         req_first_x  <= COORD_WIDTH'($urandom);
         req_first_y  <= COORD_WIDTH'($urandom);
         req_second_x <= COORD_WIDTH'($urandom);
         req_second_y <= COORD_WIDTH'($urandom);
         @(negedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      logic signed [COORD_WIDTH-1:0] fx, fy, sx, sy;
      reset        = 1'b1;
      start        = 1'b0;
      req_first_x  = '0;
      req_first_y  = '0;
      req_second_x = '0;
      req_second_y = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_pair(0, 0, 100, 200);
      send_pair(300, -7, 0, 0);
      send_pair(0, 0, 0, 0);
      send_pair(1, 0, 0, 1);
      send_pair(0, 1, 1, 0);
      send_pair(1, 0, -1, 0);
      send_pair(0, 1, 0, -1);
      send_pair(-1, 0, 1, 0);
      send_pair(MIN_COORD, 0, MAX_COORD, 0);
      send_pair(MIN_COORD, MIN_COORD, MAX_COORD, MAX_COORD);
      send_pair(MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD);
      send_pair(MIN_COORD, MAX_COORD, MAX_COORD, MIN_COORD);
      hold_off(3);
      send_pair(-5, 9, -5, -9);
      send_pair(-5, -9, -5, 9);
      send_pair(MIN_COORD, 1, MIN_COORD, -1);
      send_pair(MIN_COORD, -1, MIN_COORD, 1);
      send_pair(1234, -4321, 1234, -4321);
      send_pair(MAX_COORD, -1, MAX_COORD, 1);
      send_pair(0, MIN_COORD, 0, MAX_COORD);
      send_pair(-1, -1, 1, 1);
      send_pair(MIN_COORD, 0, 0, MIN_COORD);
      drain_results();

      for (int i = 0; i < ITEM_COUNT; i++) begin
         fx = pick_coord();
         fy = pick_coord();
         case ($urandom_range(0, 7))
            0: begin
               sx = fx;
               sy = fy;
            end
            1: begin
               sx = -fx;
               sy = -fy;
            end
            2: begin
               sx = -fy;
               sy = fx;
            end
            default: begin
               sx = pick_coord();
               sy = pick_coord();
            end
         endcase
         send_pair(fx, fy, sx, sy);
         if (i == ITEM_COUNT / 2)
            drain_results();
         else if (i < ITEM_COUNT - QUIET_TAIL && (i / 40) % 2 == 0
                  && $urandom_range(0, 2) == 0)
            hold_off($urandom_range(1, 13));
      end

      drain_results();
      repeat (RSP_LATENCY + 8) @(negedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> filelist.f
src/sabv_pkg.sv
src/sabv_front.sv
src/sabv_queue.sv
src/sabv_lane.sv
src/sabv_back.sv
src/signed_angle_between_vectors_unit.sv
src/sabv_checker.sv
dv/sabv_angle_checker.sv
dv/signed_angle_between_vectors_unit_tb.sv
